// ----- rtl/iat_pkg.sv -----
package iat_pkg;

  localparam logic [2:0] OP_CLAIM     = 3'd0;
  localparam logic [2:0] OP_CLAIM_REJ = 3'd1;
  localparam logic [2:0] OP_COMPLETE  = 3'd2;
  localparam logic [2:0] OP_REJECT    = 3'd3;
  localparam logic [2:0] OP_FIND      = 3'd4;
  localparam logic [2:0] OP_CLEAR     = 3'd5;

  localparam logic [2:0] OUT_ADMITTED  = 3'd0;
  localparam logic [2:0] OUT_DUP_PROC  = 3'd1;
  localparam logic [2:0] OUT_DUP_DONE  = 3'd2;
  localparam logic [2:0] OUT_COLLISION = 3'd3;
  localparam logic [2:0] OUT_LANE_BUSY = 3'd4;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_LANE = 2'd1;
  localparam logic [1:0] KIND_RING = 2'd2;

  localparam int unsigned TOK_W = 128;
  localparam int unsigned FP_W  = 256;
  localparam logic [6:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic start;
    logic lane_scan;
    logic ring_scan;
    logic exec;
    logic store;
    logic resp;
  } cmd_t;

  typedef struct packed {
    logic search_op;
    logic lane_hit;
    logic lane_last;
    logic ring_hit;
    logic ring_done;
    logic need_store;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/iat_ctrl.sv -----
module iat_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  iat_pkg::sts_t sts_i,
  output iat_pkg::cmd_t cmd_o
);
  import iat_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LSCAN = 6'b000010,
    ST_RSCAN = 6'b000100,
    ST_EXEC  = 6'b001000,
    ST_STORE = 6'b010000,
    ST_RESP  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d = sts_i.search_op ? ST_LSCAN : ST_EXEC;
        end
      end
      ST_LSCAN: begin
        cmd_o.lane_scan = 1'b1;
        if (sts_i.lane_hit) state_d = ST_EXEC;
        else if (sts_i.lane_last) state_d = ST_RSCAN;
      end
      ST_RSCAN: begin
        cmd_o.ring_scan = 1'b1;
        if (sts_i.ring_hit || sts_i.ring_done) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d = sts_i.need_store ? ST_STORE : ST_RESP;
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.resp = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/iat_dp.sv -----
module iat_dp #(
  parameter int unsigned LANES       = 16,
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned RESULT_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  iat_pkg::cmd_t cmd_i,
  output iat_pkg::sts_t sts_o,
  input  logic          cfg_valid_i,
  input  logic [6:0]    cfg_data_i,
  input  logic [2:0]    op_i,
  input  logic [63:0]   token_hi_i,
  input  logic [63:0]   token_lo_i,
  input  logic [63:0]   fp_word0_i,
  input  logic [63:0]   fp_word1_i,
  input  logic [63:0]   fp_word2_i,
  input  logic [63:0]   fp_word3_i,
  input  logic [3:0]    lane_i,
  input  logic [31:0]   result_in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [2:0]    outcome_o,
  output logic          accepted_o,
  output logic          result_valid_o,
  output logic [31:0]   result_out_o,
  output logic [6:0]    entry_count_o,
  output logic [4:0]    processing_count_o
);
  import iat_pkg::*;

  localparam int unsigned LW  = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned PW  = $clog2(LANES + 1);
  localparam int unsigned CW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned FW  = $clog2(CAPACITY + 1);
  localparam int unsigned MW  = (FW > 7) ? FW : 7;
  localparam int unsigned SRB = (RESULT_BITS < 32) ? RESULT_BITS : 32;
  localparam int unsigned LE_W = TOK_W + FP_W;
  localparam int unsigned RE_W = TOK_W + FP_W + SRB;

  // Lane index folded into range by a small constant table.
  logic [LW-1:0] lmod [16];
  for (genvar g = 0; g < 16; g++) begin : g_lmod
    assign lmod[g] = LW'(g % LANES);
  end

  logic [LE_W-1:0] lmem [LANES];
  logic [RE_W-1:0] rmem [CAPACITY];

  logic [2:0]       op_q;
  logic [TOK_W-1:0] tok_q;
  logic [FP_W-1:0]  fp_q, hit_fp_q, wfp_q;
  logic [LW-1:0]    ln_q, hit_lane_q, lk_q, lidx_q;
  logic [SRB-1:0]   res_q, hit_res_q;
  logic [1:0]       hit_kind_q;
  logic [LANES-1:0] busy_q;
  logic [PW-1:0]    pcount_q;
  logic [CW-1:0]    oldest_q, rslot_q;
  logic [FW-1:0]    fill_q, rk_q;
  logic [6:0]       cap_q;
  logic             lvalid_q, rvalid_q;
  logic [LE_W-1:0]  lrd_q;
  logic [RE_W-1:0]  rrd_q;

  logic [2:0]  r_outcome_q;
  logic        r_acc_q, r_rv_q;
  logic        out_valid_q;
  logic [2:0]  out_outcome_q;
  logic        out_acc_q, out_rv_q;
  logic [31:0] out_res_q;
  logic [6:0]  out_entry_q;
  logic [4:0]  out_proc_q;

  logic lmatch, rmatch;
  assign lmatch = lvalid_q && busy_q[lidx_q] && (lrd_q[LE_W-1 -: TOK_W] == tok_q);
  assign rmatch = rvalid_q && (rrd_q[RE_W-1 -: TOK_W] == tok_q);

  assign sts_o.search_op  = (op_i <= OP_FIND);
  assign sts_o.lane_hit   = lmatch;
  assign sts_o.lane_last  = lvalid_q && (lidx_q == LW'(LANES - 1)) && !lmatch;
  assign sts_o.ring_hit   = rmatch;
  assign sts_o.ring_done  = !rvalid_q && (rk_q >= fill_q);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  // Capacity clamped to 1..CAPACITY.
  logic [FW-1:0] capc;
  always_comb begin
    if (cap_q == 7'd0) capc = FW'(1);
    else if (MW'(cap_q) > MW'(CAPACITY)) capc = FW'(CAPACITY);
    else capc = FW'(cap_q);
  end

  // Operation decision.
  logic [2:0] outcome;
  logic       acc, rv, need_store, admit, release_l;
  logic [FP_W-1:0] wfp;
  always_comb begin
    outcome    = OUT_ADMITTED;
    acc        = 1'b0;
    rv         = 1'b0;
    need_store = 1'b0;
    admit      = 1'b0;
    release_l  = 1'b0;
    wfp        = fp_q;
    unique case (op_q)
      OP_CLAIM, OP_CLAIM_REJ: begin
        if (hit_kind_q != KIND_NONE) begin
          if (hit_fp_q != fp_q) outcome = OUT_COLLISION;
          else if (hit_kind_q == KIND_RING) outcome = OUT_DUP_DONE;
          else outcome = OUT_DUP_PROC;
        end else if (busy_q[ln_q]) begin
          outcome    = OUT_LANE_BUSY;
          need_store = (op_q == OP_CLAIM_REJ);
        end else begin
          admit = 1'b1;
        end
      end
      OP_COMPLETE: begin
        if (hit_kind_q == KIND_LANE) begin
          release_l  = 1'b1;
          need_store = 1'b1;
          acc        = 1'b1;
          wfp        = hit_fp_q;
        end
      end
      OP_REJECT: begin
        if (hit_kind_q == KIND_NONE) begin
          need_store = 1'b1;
          acc        = 1'b1;
        end
      end
      OP_FIND: rv = (hit_kind_q == KIND_RING);
      default: ;
    endcase
  end
  assign sts_o.need_store = need_store;

  // Eviction: drop enough oldest entries so one more fits.
  logic [FW-1:0] drop;
  logic [CW:0]   old_sum, slot_sum;
  logic [CW-1:0] old_wrap, slot;
  always_comb begin
    drop     = fill_q - capc + FW'(1);
    old_sum  = (CW+1)'(oldest_q) + (CW+1)'(drop);
    old_wrap = (old_sum >= (CW+1)'(CAPACITY)) ? CW'(old_sum - (CW+1)'(CAPACITY))
                                              : CW'(old_sum);
    slot_sum = (CW+1)'(oldest_q) + (CW+1)'(fill_q);
    slot     = (slot_sum >= (CW+1)'(CAPACITY)) ? CW'(slot_sum - (CW+1)'(CAPACITY))
                                               : CW'(slot_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= '0;
      pcount_q    <= '0;
      oldest_q    <= '0;
      fill_q      <= '0;
      cap_q       <= CAP_RESET;
      hit_kind_q  <= KIND_NONE;
      lk_q        <= '0;
      lidx_q      <= '0;
      lvalid_q    <= 1'b0;
      rk_q        <= '0;
      rslot_q     <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) cap_q <= cfg_data_i;
      if (cmd_i.start) begin
        hit_kind_q <= KIND_NONE;
        lk_q       <= '0;
        lvalid_q   <= 1'b0;
        rk_q       <= '0;
        rslot_q    <= oldest_q;
        rvalid_q   <= 1'b0;
      end
      if (cmd_i.lane_scan) begin
        lvalid_q <= 1'b1;
        lidx_q   <= lk_q;
        if (lk_q != LW'(LANES - 1)) lk_q <= lk_q + LW'(1);
        if (lmatch) hit_kind_q <= KIND_LANE;
      end
      if (cmd_i.ring_scan) begin
        if (rk_q < fill_q) begin
          rvalid_q <= 1'b1;
          rk_q     <= rk_q + FW'(1);
          rslot_q  <= (rslot_q == CW'(CAPACITY - 1)) ? '0 : rslot_q + CW'(1);
        end else begin
          rvalid_q <= 1'b0;
        end
        if (rmatch) hit_kind_q <= KIND_RING;
      end
      if (cmd_i.exec) begin
        if (op_q == OP_CLEAR) begin
          busy_q   <= '0;
          pcount_q <= '0;
          oldest_q <= '0;
          fill_q   <= '0;
        end else begin
          if (admit) begin
            busy_q[ln_q] <= 1'b1;
            pcount_q     <= pcount_q + PW'(1);
          end
          if (release_l) begin
            busy_q[hit_lane_q] <= 1'b0;
            pcount_q           <= pcount_q - PW'(1);
          end
          if (need_store && (fill_q >= capc)) begin
            oldest_q <= old_wrap;
            fill_q   <= capc - FW'(1);
          end
        end
      end
      if (cmd_i.store) fill_q <= fill_q + FW'(1);
      if (cmd_i.resp) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q  <= op_i;
      tok_q <= {token_hi_i, token_lo_i};
      fp_q  <= {fp_word0_i, fp_word1_i, fp_word2_i, fp_word3_i};
      ln_q  <= lmod[lane_i];
      res_q <= result_in_i[SRB-1:0];
    end
    if (cmd_i.lane_scan && lmatch) begin
      hit_lane_q <= lidx_q;
      hit_fp_q   <= lrd_q[FP_W-1:0];
    end
    if (cmd_i.ring_scan && rmatch) begin
      hit_fp_q  <= rrd_q[SRB +: FP_W];
      hit_res_q <= rrd_q[SRB-1:0];
    end
    if (cmd_i.exec) begin
      wfp_q       <= wfp;
      r_outcome_q <= outcome;
      r_acc_q     <= acc;
      r_rv_q      <= rv;
    end
    if (cmd_i.resp) begin
      out_outcome_q <= r_outcome_q;
      out_acc_q     <= r_acc_q;
      out_rv_q      <= r_rv_q;
      out_res_q     <= r_rv_q ? 32'(hit_res_q) : 32'd0;
      out_entry_q   <= 7'(fill_q + FW'(pcount_q));
      out_proc_q    <= 5'(pcount_q);
    end
  end

  // Lane slot memory: write on admit, read during the lane sweep.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && admit && (op_q != OP_CLEAR)) lmem[ln_q] <= {tok_q, fp_q};
    if (cmd_i.lane_scan) lrd_q <= lmem[lk_q];
  end

  // Completed ring memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) rmem[slot] <= {tok_q, wfp_q, res_q};
    if (cmd_i.ring_scan) rrd_q <= rmem[rslot_q];
  end

  assign out_valid_o        = out_valid_q;
  assign outcome_o          = out_outcome_q;
  assign accepted_o         = out_acc_q;
  assign result_valid_o     = out_rv_q;
  assign result_out_o       = out_res_q;
  assign entry_count_o      = out_entry_q;
  assign processing_count_o = out_proc_q;

  a_pcount: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcount_q == PW'($countones(busy_q)))
    else $error("processing count out of step with lane flags");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(CAPACITY))
    else $error("ring fill above capacity");
  a_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.resp |=> out_valid_q)
    else $error("result load did not raise out_valid");

endmodule

// ----- rtl/idempotency_ack_table_unit.sv -----
// Search ops sweep the LANES lane slots then the filled ring entries; clear and undefined ops
//   skip both sweeps. A hit ends the sweep early, and ops that keep an entry pass through the
//   ring store state before the result is loaded.
// Throughput: one item at a time; the single-read-port lane and ring memories set the sweep.
// The result register frees the input side while a result waits to be taken.
// Reset (rst_ni low, async): lanes idle, ring empty, capacity_in_use = 64, no result pending.
module idempotency_ack_table_unit #(
  parameter int unsigned LANES       = 16,
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned RESULT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // capacity_in_use write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [63:0] token_hi_i,
  input  logic [63:0] token_lo_i,
  input  logic [63:0] fp_word0_i,
  input  logic [63:0] fp_word1_i,
  input  logic [63:0] fp_word2_i,
  input  logic [63:0] fp_word3_i,
  input  logic [3:0]  lane_i,
  input  logic [31:0] result_in_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  outcome_o,
  output logic        accepted_o,
  output logic        result_valid_o,
  output logic [31:0] result_out_o,
  output logic [6:0]  entry_count_o,
  output logic [4:0]  processing_count_o
);
  import iat_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The user must write only while idle; the block does not enforce it and always takes the transfer.
  assign cfg_ready_o = 1'b1;

  // Sequencer: idle, lane sweep, ring sweep, execute, ring store, respond.
  iat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage, compare, eviction arithmetic and the output register.
  iat_dp #(
    .LANES       (LANES),
    .CAPACITY    (CAPACITY),
    .RESULT_BITS (RESULT_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_valid_i        (cfg_valid_i & cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .op_i               (op_i),
    .token_hi_i         (token_hi_i),
    .token_lo_i         (token_lo_i),
    .fp_word0_i         (fp_word0_i),
    .fp_word1_i         (fp_word1_i),
    .fp_word2_i         (fp_word2_i),
    .fp_word3_i         (fp_word3_i),
    .lane_i             (lane_i),
    .result_in_i        (result_in_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .outcome_o          (outcome_o),
    .accepted_o         (accepted_o),
    .result_valid_o     (result_valid_o),
    .result_out_o       (result_out_o),
    .entry_count_o      (entry_count_o),
    .processing_count_o (processing_count_o)
  );

endmodule

// ----- tb/tb.sv -----
module tb;
  import iat_pkg::*;

  typedef struct {
    logic [2:0]   op;
    logic [127:0] token;
    logic [255:0] fp;
    logic [3:0]   lane;
    logic [31:0]  res;
  } ack_req_t;

  typedef struct {
    logic [2:0]  outcome;
    logic        accepted;
    logic        result_valid;
    logic [31:0] result_out;
    logic [6:0]  entry_count;
    logic [4:0]  processing_count;
  } ack_rsp_t;

  localparam int NLANES = 16;
  localparam int NSLOTS = 64;
  localparam int POOL   = 24;

  // Table predictor: keeps its own lanes, completed ring and capacity, and
  // queues the response every accepted request should produce.
  class ack_table_model;
    logic         lane_busy [NLANES];
    logic [127:0] lane_tok  [NLANES];
    logic [255:0] lane_fp   [NLANES];
    logic [127:0] ring_tok  [NSLOTS];
    logic [255:0] ring_fp   [NSLOTS];
    logic [31:0]  ring_res  [NSLOTS];
    int           ring_oldest;
    int           ring_fill;
    int           capacity;
    ack_rsp_t     expected_acks[$];
    int           errors;

    function new();
      capacity = CAP_RESET;
      errors   = 0;
      empty_all();
    endfunction

    function void empty_all();
      foreach (lane_busy[k]) lane_busy[k] = 1'b0;
      ring_oldest = 0;
      ring_fill   = 0;
    endfunction

    function void set_capacity(logic [6:0] v);
      capacity = v;
    endfunction

    // 0 absent, 1 processing in a lane, 2 completed in a ring slot
    function int locate(logic [127:0] tok, output int where);
      int s;
      where = 0;
      for (int k = 0; k < NLANES; k++)
        if (lane_busy[k] && lane_tok[k] == tok) begin
          where = k;
          return 1;
        end
      for (int k = 0; k < ring_fill; k++) begin
        s = (ring_oldest + k) % NSLOTS;
        if (ring_tok[s] == tok) begin
          where = s;
          return 2;
        end
      end
      return 0;
    endfunction

    function void store_done(logic [127:0] tok, logic [255:0] fp, logic [31:0] res);
      int cap;
      int s;
      cap = capacity < 1 ? 1 : (capacity > NSLOTS ? NSLOTS : capacity);
      // evict oldest entries until the new one fits
      while (ring_fill >= cap) begin
        ring_oldest = (ring_oldest + 1) % NSLOTS;
        ring_fill--;
      end
      s = (ring_oldest + ring_fill) % NSLOTS;
      ring_tok[s] = tok;
      ring_fp[s]  = fp;
      ring_res[s] = res;
      ring_fill++;
    endfunction

    function void note_request(ack_req_t r);
      ack_rsp_t e;
      int kind;
      int where;
      int busy;
      logic [255:0] have;
      e = '{default: '0};
      if (r.op <= OP_FIND) begin
        kind = locate(r.token, where);
        if (r.op == OP_CLAIM || r.op == OP_CLAIM_REJ) begin
          if (kind != 0) begin
            have = (kind == 1) ? lane_fp[where] : ring_fp[where];
            if (have != r.fp) e.outcome = OUT_COLLISION;
            else e.outcome = (kind == 2) ? OUT_DUP_DONE : OUT_DUP_PROC;
          end else if (lane_busy[r.lane]) begin
            if (r.op == OP_CLAIM_REJ) store_done(r.token, r.fp, r.res);
            e.outcome = OUT_LANE_BUSY;
          end else begin
            lane_busy[r.lane] = 1'b1;
            lane_tok[r.lane]  = r.token;
            lane_fp[r.lane]   = r.fp;
            e.outcome = OUT_ADMITTED;
          end
        end else if (r.op == OP_COMPLETE) begin
          if (kind == 1) begin
            lane_busy[where] = 1'b0;
            store_done(r.token, lane_fp[where], r.res);
            e.accepted = 1'b1;
          end
        end else if (r.op == OP_REJECT) begin
          if (kind == 0) begin
            store_done(r.token, r.fp, r.res);
            e.accepted = 1'b1;
          end
        end else if (kind == 2) begin
          e.result_valid = 1'b1;
          e.result_out   = ring_res[where];
        end
      end else if (r.op == OP_CLEAR) begin
        empty_all();
      end
      busy = 0;
      foreach (lane_busy[k]) if (lane_busy[k]) busy++;
      e.entry_count      = 7'(ring_fill + busy);
      e.processing_count = 5'(busy);
      expected_acks = {expected_acks, e};
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(ack_rsp_t got);
      ack_rsp_t e;
      if (expected_acks.size() == 0) begin
        report("response with nothing outstanding");
        return;
      end
      e = expected_acks[0];
      expected_acks.delete(0);
      if (got.outcome !== e.outcome)
        report($sformatf("outcome %0d, want %0d", got.outcome, e.outcome));
      if (got.accepted !== e.accepted)
        report($sformatf("accepted %0d, want %0d", got.accepted, e.accepted));
      if (got.result_valid !== e.result_valid)
        report($sformatf("result_valid %0d, want %0d", got.result_valid, e.result_valid));
      if (got.result_out !== e.result_out)
        report($sformatf("result_out %h, want %h", got.result_out, e.result_out));
      if (got.entry_count !== e.entry_count)
        report($sformatf("entry_count %0d, want %0d", got.entry_count, e.entry_count));
      if (got.processing_count !== e.processing_count)
        report($sformatf("processing_count %0d, want %0d",
                         got.processing_count, e.processing_count));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  op_i;
  logic [63:0] token_hi_i, token_lo_i;
  logic [63:0] fp_word0_i, fp_word1_i, fp_word2_i, fp_word3_i;
  logic [3:0]  lane_i;
  logic [31:0] result_in_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  outcome_o;
  logic        accepted_o;
  logic        result_valid_o;
  logic [31:0] result_out_o;
  logic [6:0]  entry_count_o;
  logic [4:0]  processing_count_o;

  idempotency_ack_table_unit dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_stall_o, .op_i, .token_hi_i, .token_lo_i,
    .fp_word0_i, .fp_word1_i, .fp_word2_i, .fp_word3_i, .lane_i, .result_in_i,
    .out_valid_o, .out_stall_i, .outcome_o, .accepted_o, .result_valid_o,
    .result_out_o, .entry_count_o, .processing_count_o
  );

  ack_table_model model = new();

  // Small token pool so claims, completions and finds keep hitting each other.
  logic [127:0] tok_pool [POOL];
  logic [255:0] fp_pool  [POOL];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #40000000;
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: take responses and stall in runs of random mode and length.
  int stall_left = 0;
  int stall_mode = 0;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      model.check_result('{outcome_o, accepted_o, result_valid_o, result_out_o,
                           entry_count_o, processing_count_o});
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(1, 60);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Write capacity_in_use; only called with nothing outstanding.
  task write_capacity(logic [6:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    model.set_capacity(v);
    cfg_valid_i <= 1'b0;
  endtask

  // Present one request and hold it until the transfer happens.
  // Valid is left high so a back-to-back request needs no second assignment.
  task send_req(ack_req_t r);
    in_valid_i  <= 1'b1;
    op_i        <= r.op;
    {token_hi_i, token_lo_i} <= r.token;
    {fp_word0_i, fp_word1_i, fp_word2_i, fp_word3_i} <= r.fp;
    lane_i      <= r.lane;
    result_in_i <= r.res;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    model.note_request(r);
  endtask

  task idle_cycles(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Drain all outstanding responses, then let the block settle.
  task drain();
    idle_cycles(1);
    while (model.expected_acks.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  function ack_req_t mk(logic [2:0] op, int idx, bit alt_fp, logic [3:0] ln,
                        logic [31:0] res);
    ack_req_t r;
    r.op    = op;
    r.token = tok_pool[idx];
    r.fp    = alt_fp ? ~fp_pool[idx] : fp_pool[idx];
    r.lane  = ln;
    r.res   = res;
    return r;
  endfunction

  function ack_req_t rand_req();
    ack_req_t r;
    int w;
    w = $urandom_range(0, 99);
    // weight toward claim/complete/find so entries cycle through every state
    r.op = w < 25 ? OP_CLAIM : w < 35 ? OP_CLAIM_REJ : w < 60 ? OP_COMPLETE :
           w < 70 ? OP_REJECT : w < 95 ? OP_FIND : w < 97 ? OP_CLEAR :
           3'($urandom_range(6, 7));
    r = mk(r.op, $urandom_range(0, POOL - 1), 1'b0, 4'($urandom_range(0, 15)),
           $urandom());
    if ($urandom_range(0, 9) == 0) r.fp = {$urandom(), $urandom(), $urandom(), $urandom(),
                                           $urandom(), $urandom(), $urandom(), $urandom()};
    if ($urandom_range(0, 19) == 0)
      r.token = {$urandom(), $urandom(), $urandom(), $urandom()};
    return r;
  endfunction

  task random_phase(int n);
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 100));
      end
      burst--;
      send_req(rand_req());
      // pause mid-phase until every response is back
      if (i == n / 2) drain();
    end
  endtask

  logic [6:0] cap_plan [6] = '{7'd1, 7'd0, 7'd127, 7'd3, 7'd64, 7'd17};

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    op_i        = '0;
    token_hi_i  = '0;
    token_lo_i  = '0;
    fp_word0_i  = '0;
    fp_word1_i  = '0;
    fp_word2_i  = '0;
    fp_word3_i  = '0;
    lane_i      = '0;
    result_in_i = '0;
    out_stall_i = 1'b0;
    for (int k = 0; k < POOL; k++) begin
      tok_pool[k] = {$urandom(), $urandom(), $urandom(), $urandom()};
      fp_pool[k]  = {$urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom(), $urandom()};
    end
    // extreme tokens and fingerprints
    tok_pool[0] = '0;
    fp_pool[0]  = '0;
    tok_pool[1] = '1;
    fp_pool[1]  = '1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    // Directed: every claim outcome, completion paths, finds, clear, bad ops.
    send_req(mk(OP_CLAIM,     0, 1'b0, 4'd0,  32'h0));          // admitted
    send_req(mk(OP_CLAIM,     0, 1'b0, 4'd5,  32'h0));          // already processing
    send_req(mk(OP_CLAIM,     0, 1'b1, 4'd5,  32'h0));          // fingerprint collision
    send_req(mk(OP_CLAIM,     2, 1'b0, 4'd0,  32'h1));          // lane busy, nothing kept
    send_req(mk(OP_CLAIM_REJ, 1, 1'b0, 4'd0,  32'hffff_ffff));  // lane busy, kept as done
    send_req(mk(OP_FIND,      1, 1'b0, 4'd15, 32'h0));
    send_req(mk(OP_FIND,      0, 1'b0, 4'd0,  32'h0));          // processing: no result
    send_req(mk(OP_COMPLETE,  0, 1'b1, 4'd9,  32'hdead_beef));  // lane fingerprint is kept
    send_req(mk(OP_COMPLETE,  0, 1'b0, 4'd0,  32'h5));          // already done
    send_req(mk(OP_COMPLETE,  3, 1'b0, 4'd0,  32'h5));          // unknown
    send_req(mk(OP_CLAIM,     0, 1'b0, 4'd0,  32'h0));          // duplicate completed
    send_req(mk(OP_CLAIM,     0, 1'b1, 4'd0,  32'h0));          // collision vs ring
    send_req(mk(OP_FIND,      0, 1'b0, 4'd0,  32'h0));
    send_req(mk(OP_FIND,      4, 1'b0, 4'd0,  32'h0));          // unknown
    send_req(mk(OP_REJECT,    4, 1'b0, 4'd15, 32'h1234_5678));
    send_req(mk(OP_REJECT,    4, 1'b0, 4'd15, 32'h0));          // known: no effect
    send_req(mk(OP_CLAIM,     5, 1'b0, 4'd15, 32'h0));
    send_req(mk(OP_REJECT,    5, 1'b0, 4'd3,  32'h0));          // processing: no effect
    send_req(mk(3'd6,         5, 1'b0, 4'd3,  32'h0));
    send_req(mk(3'd7,         5, 1'b0, 4'd3,  32'h0));
    send_req(mk(OP_CLEAR,     5, 1'b0, 4'd3,  32'h0));
    send_req(mk(OP_FIND,      4, 1'b0, 4'd0,  32'h0));          // gone after clear
    send_req(mk(OP_CLAIM,     5, 1'b0, 4'd15, 32'h0));
    drain();

    random_phase(200);
    foreach (cap_plan[p]) begin
      drain();
      write_capacity(cap_plan[p]);
      random_phase(180);
    end
    drain();

    if (model.errors == 0 && model.expected_acks.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/iat_pkg.sv
rtl/iat_ctrl.sv
rtl/iat_dp.sv
rtl/idempotency_ack_table_unit.sv
tb/tb.sv
